/* src/gdad_pkg.sv */
// ----------------------------------------------------------------------------
// gdad_pkg: shared types and constants for the Gregorian date adder
// Holds the control word layout and the micro-program for the sequencer.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int unsigned YearInW    = 15;
  localparam int unsigned YearW      = 16;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned DayW       = 5;
  localparam int unsigned CountW     = 16;
  localparam int unsigned SumW       = 17;  // start day plus count, at most 65566
  localparam int unsigned PcW        = 2;
  localparam int unsigned RemW       = 15;
  localparam int unsigned ProdW      = 30;  // year times the reciprocal of 100
  localparam int unsigned QuotW      = 9;   // year / 100 is at most 327
  localparam int unsigned RecipShift = 21;

  // ceil(2^21 / 100); the scaled product gives year / 100 exactly below 32768.
  localparam logic [RemW-1:0]   Recip100 = 15'd20972;
  localparam logic [RemW-1:0]   Century  = 15'd100;
  localparam logic [MonthW-1:0] January  = 4'd1;
  localparam logic [MonthW-1:0] February = 4'd2;
  localparam logic [MonthW-1:0] December = 4'd12;

  // Month length table; codes 0 and 13 to 15 have length zero.
  localparam logic [DayW-1:0] MonthLen [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // Jump conditions of the micro-program.
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_FIT      // day still exceeds the current month length
  } cond_t;

  typedef struct packed {
    logic            div_step;
    logic            split_step;
    logic            walk_step;
    logic            finish;
    cond_t           cond;
    logic [PcW-1:0]  target;
  } ctrl_word_t;

  localparam logic [PcW-1:0] PcDiv    = 2'd0;
  localparam logic [PcW-1:0] PcSplit  = 2'd1;
  localparam logic [PcW-1:0] PcWalk   = 2'd2;
  localparam logic [PcW-1:0] PcFinish = 2'd3;

  // Micro-program: divide the year by 100, walk the months, deliver the date.
  localparam ctrl_word_t Program [4] = '{
    '{div_step: 1'b1, split_step: 1'b0, walk_step: 1'b0, finish: 1'b0,
      cond: COND_NEVER, target: PcSplit},
    '{div_step: 1'b0, split_step: 1'b1, walk_step: 1'b0, finish: 1'b0,
      cond: COND_NEVER, target: PcWalk},
    '{div_step: 1'b0, split_step: 1'b0, walk_step: 1'b1, finish: 1'b0,
      cond: COND_NO_FIT, target: PcWalk},
    '{div_step: 1'b0, split_step: 1'b0, walk_step: 1'b0, finish: 1'b1,
      cond: COND_NEVER, target: PcFinish}
  };

endpackage

/* src/gregorian_date_add_days.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days: adds a count of days to a Gregorian date
// A small micro-programmed sequencer drives a year, month and day datapath.
// ----------------------------------------------------------------------------
// Sequence: the year is split by 100 (a reciprocal multiply, then the
// remainder), then one month is walked per cycle, then the final month test
// is made and the result is handed over once the output register is free; at
// most about 2160 months are crossed.
// One item at a time: the next transfer is taken the cycle after the result
// enters the output register, so a new item waits until the last is done.
// The month walk, one month a cycle, takes most of the time.
// Reset (rst, synchronous, active high) clears the sequencer and output valid.
module gregorian_date_add_days (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: start_year[14:0], start_month[3:0], start_day[4:0],
  // day_count[15:0]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: end_year[15:0], end_month[3:0], end_day[4:0], zeros
  output logic [31:0] m_tdata
);
  import gdad_pkg::*;

  // Sequencer state: busy marks an item in work, pc is the micro-program step.
  logic             busy;
  logic [PcW-1:0]   pc;
  ctrl_word_t       cw;

  // Datapath registers.
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [SumW-1:0]   day;
  // Quotient of the start year by 100, taken from the scaled reciprocal product.
  logic [QuotW-1:0]  quot;
  // After the split rem holds the year modulo 100 and follows the year as the
  // walk advances it.
  logic [RemW-1:0]   rem;
  // The two low bits of the quotient by 100, i.e. the century modulo 4.
  logic [1:0]        cent;

  logic              in_xfer;
  logic              out_free;
  logic [ProdW-1:0]  recip_prod;
  logic              leap;
  logic [DayW-1:0]   len;
  logic              no_fit;
  logic              take_jump;

  assign cw       = Program[pc];
  assign s_tready = !busy;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign recip_prod = ProdW'(year[RemW-1:0]) * ProdW'(Recip100);

  // A year is leap when divisible by 4 but not by 100, or divisible by 400.
  // Since 100 is a multiple of 4, the year modulo 4 is the low bits of rem.
  assign leap = ((rem[1:0] == 2'd0) && (rem != '0)) || ((rem == '0) && (cent == 2'd0));

  always_comb begin
    len = MonthLen[month];
    if ((month == February) && leap) begin
      len = len + DayW'(1);
    end
  end

  assign no_fit = (day > SumW'(len));

  always_comb begin
    case (cw.cond)
      COND_NO_FIT: take_jump = no_fit;
      default:     take_jump = 1'b0;
    endcase
  end

  // Sequencer: step counter with conditional jumps taken from the control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PcDiv;
    end else if (in_xfer) begin
      busy <= 1'b1;
      pc   <= PcDiv;
    end else if (busy) begin
      if (cw.finish) begin
        if (out_free) begin
          busy <= 1'b0;
        end
      end else if (take_jump) begin
        pc <= cw.target;
      end else begin
        pc <= pc + PcW'(1);
      end
    end
  end

  // Datapath: load, year split by 100, and the month walk.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      year  <= YearW'(s_tdata[14:0]);
      month <= s_tdata[18:15];
      day   <= SumW'(s_tdata[23:19]) + SumW'(s_tdata[39:24]);
    end else if (busy) begin
      if (cw.div_step) begin
        quot <= recip_prod[RecipShift +: QuotW];
      end
      if (cw.split_step) begin
        rem  <= year[RemW-1:0] - RemW'(quot) * Century;
        cent <= quot[1:0];
      end
      if (cw.walk_step && no_fit) begin
        day <= day - SumW'(len);
        // Months 12 and the out-of-range codes above it roll into a new year.
        if (month >= December) begin
          month <= January;
          year  <= year + YearW'(1);
          if (rem == Century - RemW'(1)) begin
            rem  <= '0;
            cent <= cent + 2'd1;
          end else begin
            rem <= rem + RemW'(1);
          end
        end else begin
          month <= month + MonthW'(1);
        end
      end
    end
  end

  // Output register: the result waits here while the next item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (busy && cw.finish && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && cw.finish && out_free) begin
      m_tdata <= {7'd0, day[DayW-1:0], month, year};
    end
  end

endmodule
